@@ rtl/core/store_address_and_lane_formatter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Store address and lane formatter: assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef STORE_ADDRESS_AND_LANE_FORMATTER_TOP_MACROS_SVH
`define STORE_ADDRESS_AND_LANE_FORMATTER_TOP_MACROS_SVH

// Checked on every rising edge outside reset.
`define SALF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SALF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/salf_pkg.sv @@
// ----------------------------------------------------------------------------
// Store address and lane formatter package
// Item types, command codes, access sizes and fault codes.
// ----------------------------------------------------------------------------
package salf_pkg;

    localparam logic [3:0] CMD_SB   = 4'd0;
    localparam logic [3:0] CMD_SH   = 4'd1;
    localparam logic [3:0] CMD_SW   = 4'd2;
    localparam logic [3:0] CMD_SD   = 4'd3;
    localparam logic [3:0] CMD_SQ   = 4'd4;
    localparam logic [3:0] CMD_SWL  = 4'd5;
    localparam logic [3:0] CMD_SWR  = 4'd6;
    localparam logic [3:0] CMD_SDL  = 4'd7;
    localparam logic [3:0] CMD_SDR  = 4'd8;
    localparam logic [3:0] CMD_SWC1 = 4'd9;
    localparam logic [3:0] CMD_SQC2 = 4'd10;

    localparam logic [2:0] SIZE_BYTE  = 3'd0;
    localparam logic [2:0] SIZE_HALF  = 3'd1;
    localparam logic [2:0] SIZE_WORD  = 3'd2;
    localparam logic [2:0] SIZE_DWORD = 3'd3;
    localparam logic [2:0] SIZE_QWORD = 3'd4;

    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_FPU    = 2'd1;
    localparam logic [1:0] FAULT_VECTOR = 2'd2;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [31:0]        base;
        logic signed [15:0] offset;
        logic [63:0]        store_data_lo;
        logic [63:0]        store_data_hi;
        logic               fpu_usable;
        logic               vector_usable;
    } store_item_t;

    typedef struct packed {
        logic        do_write;
        logic [1:0]  fault;
        logic [31:0] address;
        logic [2:0]  access_size;
        logic [63:0] write_lo;
        logic [63:0] write_hi;
        logic [15:0] byte_enable;
    } write_item_t;

endpackage

@@ rtl/core/salf_format.sv @@
// ----------------------------------------------------------------------------
// Store formatter
// Forms the address, access size, data lanes and byte enables of one store, or its fault.
// ----------------------------------------------------------------------------
module salf_format
(
    input  salf_pkg::store_item_t store,
    output salf_pkg::write_item_t result
);

    logic [31:0] addr;
    logic [1:0]  k4;
    logic [2:0]  k8;
    logic [31:0] w32;
    logic [63:0] lo;

    always_comb
    begin
        addr = store.base + {{16{store.offset[15]}}, store.offset};
        k4   = addr[1:0];
        k8   = addr[2:0];
        w32  = store.store_data_lo[31:0];
        lo   = store.store_data_lo;
        result = '0;
        unique case (store.cmd)
            salf_pkg::CMD_SB:
            begin
                result.do_write    = 1'b1;
                result.address     = addr;
                result.access_size = salf_pkg::SIZE_BYTE;
                result.write_lo    = {56'b0, lo[7:0]};
                result.byte_enable = 16'h0001;
            end
            salf_pkg::CMD_SH:
            begin
                result.do_write    = 1'b1;
                result.address     = addr;
                result.access_size = salf_pkg::SIZE_HALF;
                result.write_lo    = {48'b0, lo[15:0]};
                result.byte_enable = 16'h0003;
            end
            salf_pkg::CMD_SW:
            begin
                result.do_write    = 1'b1;
                result.address     = addr;
                result.access_size = salf_pkg::SIZE_WORD;
                result.write_lo    = {32'b0, w32};
                result.byte_enable = 16'h000F;
            end
            salf_pkg::CMD_SD:
            begin
                result.do_write    = 1'b1;
                result.address     = addr;
                result.access_size = salf_pkg::SIZE_DWORD;
                result.write_lo    = lo;
                result.byte_enable = 16'h00FF;
            end
            salf_pkg::CMD_SQ:
            begin
                result.do_write    = 1'b1;
                result.address     = addr;
                result.access_size = salf_pkg::SIZE_QWORD;
                result.write_lo    = lo;
                result.write_hi    = store.store_data_hi;
                result.byte_enable = 16'hFFFF;
            end
            salf_pkg::CMD_SWL:
            begin
                result.do_write    = 1'b1;
                result.address     = {addr[31:2], 2'b0};
                result.access_size = salf_pkg::SIZE_WORD;
                result.write_lo    = {32'b0, w32 >> {~k4, 3'b0}};
                result.byte_enable = {12'b0, 4'hF >> ~k4};
            end
            salf_pkg::CMD_SWR:
            begin
                result.do_write    = 1'b1;
                result.address     = {addr[31:2], 2'b0};
                result.access_size = salf_pkg::SIZE_WORD;
                result.write_lo    = {32'b0, w32 << {k4, 3'b0}};
                result.byte_enable = {12'b0, 4'hF << k4};
            end
            salf_pkg::CMD_SDL:
            begin
                result.do_write    = 1'b1;
                result.address     = {addr[31:3], 3'b0};
                result.access_size = salf_pkg::SIZE_DWORD;
                result.write_lo    = lo >> {~k8, 3'b0};
                result.byte_enable = {8'b0, 8'hFF >> ~k8};
            end
            salf_pkg::CMD_SDR:
            begin
                result.do_write    = 1'b1;
                result.address     = {addr[31:3], 3'b0};
                result.access_size = salf_pkg::SIZE_DWORD;
                result.write_lo    = lo << {k8, 3'b0};
                result.byte_enable = {8'b0, 8'hFF << k8};
            end
            salf_pkg::CMD_SWC1:
            begin
                if (store.fpu_usable)
                begin
                    result.do_write    = 1'b1;
                    result.address     = addr;
                    result.access_size = salf_pkg::SIZE_WORD;
                    result.write_lo    = {32'b0, w32};
                    result.byte_enable = 16'h000F;
                end
                else
                begin
                    result.fault = salf_pkg::FAULT_FPU;
                end
            end
            salf_pkg::CMD_SQC2:
            begin
                if (store.vector_usable)
                begin
                    result.do_write    = 1'b1;
                    result.address     = addr;
                    result.access_size = salf_pkg::SIZE_QWORD;
                    result.write_lo    = lo;
                    result.write_hi    = store.store_data_hi;
                    result.byte_enable = 16'hFFFF;
                end
                else
                begin
                    result.fault = salf_pkg::FAULT_VECTOR;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/store_address_and_lane_formatter_top.sv @@
// ----------------------------------------------------------------------------
// Store address and lane formatter, top level
// Turns one store instruction into an address, access size, write data
// lanes and byte enables, or a coprocessor-unusable fault.
//
//   Channel   Direction   Handshake               Item
//   store     in          store_valid/stall       salf_pkg::store_item_t
//   write     out         write_valid/stall       salf_pkg::write_item_t
//
// One item is taken every cycle while the store side is not stalled. Its
// result passes through the input register and then the result register to
// the write port.
// The formatter between the two registers is one 32-bit add and lane shifts.
// Reset empties both registers. A stall on the write side holds the result
// register, and an empty input register still takes one more item before the
// store side is stalled.
// ----------------------------------------------------------------------------
module store_address_and_lane_formatter_top
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  store_valid,
    output logic                  store_stall,
    input  salf_pkg::store_item_t store_item,
    output logic                  write_valid,
    input  logic                  write_stall,
    output salf_pkg::write_item_t write_item
);

    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    salf_pkg::store_item_t stage_item_reg;
    logic                  write_valid_reg;
    logic                  write_valid_next;
    salf_pkg::write_item_t write_item_reg;
    salf_pkg::write_item_t write_item_next;
    logic                  result_free;

    salf_format u_format
    (
        .store  (stage_item_reg),
        .result (write_item_next)
    );

    always_comb
    begin
        result_free      = !write_valid_reg || !write_stall;
        store_stall      = stage_valid_reg && !result_free;
        stage_valid_next = store_stall ? stage_valid_reg : store_valid;
        write_valid_next = result_free ? stage_valid_reg : write_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            write_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            write_valid_reg <= write_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_valid && !store_stall)
        begin
            stage_item_reg <= store_item;
        end
        if (result_free && stage_valid_reg)
        begin
            write_item_reg <= write_item_next;
        end
    end

    assign write_valid = write_valid_reg;
    assign write_item  = write_item_reg;

endmodule

@@ rtl/core/salf_checker.sv @@
// ----------------------------------------------------------------------------
// Store address and lane formatter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "store_address_and_lane_formatter_top_macros.svh"

module salf_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  store_stall,
    input logic                  write_valid,
    input logic                  write_stall,
    input salf_pkg::write_item_t write_item
);

    `SALF_ASSERT(a_valid_held, write_valid && write_stall |=> write_valid,
                 "Result withdrawn while stalled.")
    `SALF_ASSERT(a_item_held, write_valid && write_stall |=> $stable(write_item),
                 "Stalled result changed.")
    `SALF_ASSERT(a_fault_no_write,
                 write_valid && write_item.fault != salf_pkg::FAULT_NONE
                 |-> !write_item.do_write && write_item.byte_enable == 16'h0000,
                 "Faulted store writes.")
    `SALF_ASSERT(a_store_stall_cause, store_stall |-> write_valid && write_stall,
                 "Store side stalled with free result register.")
    `SALF_ASSERT_ALWAYS(a_reset_empty, !$past(rst_n) |-> !write_valid,
                        "Result valid straight after reset.")

endmodule

bind store_address_and_lane_formatter_top salf_checker u_salf_checker (.*);

@@ test/store_address_and_lane_formatter_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Store address and lane formatter testbench
// Drives store items through the valid/stall handshake and works out the
// expected write item for each one. It compares every write item field by
// field in arrival order. Directed tests cover the plain, partial,
// coprocessor and unknown commands. Random items follow, with idling and
// back pressure on both sides.
// ----------------------------------------------------------------------------
module store_address_and_lane_formatter_top_test;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  store_valid;
    logic                  store_stall;
    salf_pkg::store_item_t store_item;
    logic                  write_valid;
    logic                  write_stall = 1'b0;
    salf_pkg::write_item_t write_item;

    salf_pkg::write_item_t pending_writes[$];
    int                    error_count  = 0;
    bit                    idling_on    = 1'b1;
    int                    hold_request = 0;
    int                    hold_left    = 0;

    store_address_and_lane_formatter_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .store_valid (store_valid),
        .store_stall (store_stall),
        .store_item  (store_item),
        .write_valid (write_valid),
        .write_stall (write_stall),
        .write_item  (write_item)
    );

    always #5 clk = ~clk;

    function automatic salf_pkg::write_item_t format_store(input salf_pkg::store_item_t s);
        salf_pkg::write_item_t r;
        logic [31:0] addr;
        logic [31:0] word;
        logic [31:0] shifted_word;
        int unsigned k4;
        int unsigned k8;
        r            = '0;
        addr         = s.base + {{16{s.offset[15]}}, s.offset};
        word         = s.store_data_lo[31:0];
        k4           = {30'b0, addr[1:0]};
        k8           = {29'b0, addr[2:0]};
        shifted_word = word << (8 * k4);
        r.do_write   = 1'b1;
        r.fault      = salf_pkg::FAULT_NONE;
        r.address    = addr;
        case (s.cmd)
            salf_pkg::CMD_SB:
            begin
                r.access_size = salf_pkg::SIZE_BYTE;
                r.write_lo    = {56'b0, s.store_data_lo[7:0]};
                r.byte_enable = 16'h0001;
            end
            salf_pkg::CMD_SH:
            begin
                r.access_size = salf_pkg::SIZE_HALF;
                r.write_lo    = {48'b0, s.store_data_lo[15:0]};
                r.byte_enable = 16'h0003;
            end
            salf_pkg::CMD_SW:
            begin
                r.access_size = salf_pkg::SIZE_WORD;
                r.write_lo    = {32'b0, word};
                r.byte_enable = 16'h000F;
            end
            salf_pkg::CMD_SD:
            begin
                r.access_size = salf_pkg::SIZE_DWORD;
                r.write_lo    = s.store_data_lo;
                r.byte_enable = 16'h00FF;
            end
            salf_pkg::CMD_SQ:
            begin
                r.access_size = salf_pkg::SIZE_QWORD;
                r.write_lo    = s.store_data_lo;
                r.write_hi    = s.store_data_hi;
                r.byte_enable = 16'hFFFF;
            end
            salf_pkg::CMD_SWL:
            begin
                r.address     = {addr[31:2], 2'b00};
                r.access_size = salf_pkg::SIZE_WORD;
                r.write_lo    = {32'b0, word >> (24 - 8 * k4)};
                r.byte_enable = (16'd1 << (k4 + 1)) - 16'd1;
            end
            salf_pkg::CMD_SWR:
            begin
                r.address     = {addr[31:2], 2'b00};
                r.access_size = salf_pkg::SIZE_WORD;
                r.write_lo    = {32'b0, shifted_word};
                r.byte_enable = (16'h000F << k4) & 16'h000F;
            end
            salf_pkg::CMD_SDL:
            begin
                r.address     = {addr[31:3], 3'b000};
                r.access_size = salf_pkg::SIZE_DWORD;
                r.write_lo    = s.store_data_lo >> (56 - 8 * k8);
                r.byte_enable = (16'd1 << (k8 + 1)) - 16'd1;
            end
            salf_pkg::CMD_SDR:
            begin
                r.address     = {addr[31:3], 3'b000};
                r.access_size = salf_pkg::SIZE_DWORD;
                r.write_lo    = s.store_data_lo << (8 * k8);
                r.byte_enable = (16'h00FF << k8) & 16'h00FF;
            end
            salf_pkg::CMD_SWC1:
            begin
                if (s.fpu_usable)
                begin
                    r.access_size = salf_pkg::SIZE_WORD;
                    r.write_lo    = {32'b0, word};
                    r.byte_enable = 16'h000F;
                end
                else
                begin
                    r       = '0;
                    r.fault = salf_pkg::FAULT_FPU;
                end
            end
            salf_pkg::CMD_SQC2:
            begin
                if (s.vector_usable)
                begin
                    r.access_size = salf_pkg::SIZE_QWORD;
                    r.write_lo    = s.store_data_lo;
                    r.write_hi    = s.store_data_hi;
                    r.byte_enable = 16'hFFFF;
                end
                else
                begin
                    r       = '0;
                    r.fault = salf_pkg::FAULT_VECTOR;
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic salf_pkg::store_item_t make_item(input logic [3:0] cmd,
                                                        input logic [31:0] base,
                                                        input logic [15:0] offset,
                                                        input logic [63:0] lo,
                                                        input logic [63:0] hi,
                                                        input logic fpu, input logic vec);
        salf_pkg::store_item_t s;
        s.cmd           = cmd;
        s.base          = base;
        s.offset        = offset;
        s.store_data_lo = lo;
        s.store_data_hi = hi;
        s.fpu_usable    = fpu;
        s.vector_usable = vec;
        return s;
    endfunction

    function automatic salf_pkg::store_item_t random_item();
        salf_pkg::store_item_t s;
        s.cmd = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 11))
                                         : 4'($urandom_range(10, 0));
        case ($urandom_range(15))
            0:       s.base = 32'h0000_0000;
            1:       s.base = 32'hFFFF_FFFF;
            2:       s.base = 32'hFFFF_8000;
            default: s.base = $urandom;
        endcase
        s.offset        = 16'($urandom);
        s.store_data_lo = {$urandom, $urandom};
        s.store_data_hi = {$urandom, $urandom};
        s.fpu_usable    = ($urandom_range(3) != 0);
        s.vector_usable = ($urandom_range(3) != 0);
        return s;
    endfunction

    task automatic send_store(input salf_pkg::store_item_t s);
        while (idling_on && $urandom_range(99) < 11)
        begin
            store_valid <= 1'b0;
            @(negedge clk);
        end
        store_valid <= 1'b1;
        store_item  <= s;
        @(posedge clk);
        while (store_stall)
            @(posedge clk);
        pending_writes.push_back(format_store(s));
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            write_stall <= 1'b1;
        end
        else
            write_stall <= idling_on && ($urandom_range(99) < 11);
    end

    always @(posedge clk)
    begin
        salf_pkg::write_item_t want;
        if (rst_n && write_valid && !write_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("write item arrived with none expected");
                error_count++;
            end
            else
            begin
                want = pending_writes.pop_front();
                check_field("do_write", 64'(want.do_write), 64'(write_item.do_write));
                check_field("fault", 64'(want.fault), 64'(write_item.fault));
                check_field("address", 64'(want.address), 64'(write_item.address));
                check_field("access_size", 64'(want.access_size),
                            64'(write_item.access_size));
                check_field("write_lo", want.write_lo, write_item.write_lo);
                check_field("write_hi", want.write_hi, write_item.write_hi);
                check_field("byte_enable", 64'(want.byte_enable),
                            64'(write_item.byte_enable));
            end
        end
    end

    task automatic test_plain_stores();
        send_store(make_item(salf_pkg::CMD_SB, 32'h0000_0000, 16'hFFFF,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
        send_store(make_item(salf_pkg::CMD_SH, 32'hFFFF_FFFF, 16'h0001,
                             64'h0123_4567_89AB_CDEF, 64'h0, 1'b0, 1'b0));
        send_store(make_item(salf_pkg::CMD_SW, 32'h1234_5678, 16'h7FFF,
                             64'hFEDC_BA98_7654_3210, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0));
        send_store(make_item(salf_pkg::CMD_SD, 32'h0000_0000, 16'h8000,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b1));
        send_store(make_item(salf_pkg::CMD_SQ, 32'hFFFF_FFF3, 16'h0000,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
    endtask

    task automatic test_partial_stores();
        for (int k = 0; k < 4; k++)
        begin
            send_store(make_item(salf_pkg::CMD_SWL, 32'h8000_0000, 16'(k),
                                 64'h1122_3344_5566_7788, 64'h0, 1'b1, 1'b1));
            send_store(make_item(salf_pkg::CMD_SWR, 32'h7FFF_FFFC, 16'(k),
                                 64'h1122_3344_5566_7788, 64'h0, 1'b1, 1'b1));
        end
        send_store(make_item(salf_pkg::CMD_SDL, 32'hFFFF_FFF8, 16'h0000,
                             64'h0102_0304_0506_0708, 64'h0, 1'b1, 1'b1));
        send_store(make_item(salf_pkg::CMD_SDL, 32'h0000_0000, 16'h0003,
                             64'h0102_0304_0506_0708, 64'h0, 1'b1, 1'b1));
        send_store(make_item(salf_pkg::CMD_SDL, 32'h0000_0010, 16'hFFFF,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 1'b1));
        send_store(make_item(salf_pkg::CMD_SDR, 32'h0000_0000, 16'h0000,
                             64'h0102_0304_0506_0708, 64'h0, 1'b1, 1'b1));
        send_store(make_item(salf_pkg::CMD_SDR, 32'hFFFF_FFFC, 16'h0000,
                             64'h0102_0304_0506_0708, 64'h0, 1'b1, 1'b1));
        send_store(make_item(salf_pkg::CMD_SDR, 32'hFFFF_FFFF, 16'h0000,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 1'b1));
    endtask

    task automatic test_coprocessor_stores();
        send_store(make_item(salf_pkg::CMD_SWC1, 32'h0000_1000, 16'h0004,
                             64'hDEAD_BEEF_CAFE_F00D, 64'h0, 1'b1, 1'b0));
        send_store(make_item(salf_pkg::CMD_SWC1, 32'h0000_1000, 16'h0004,
                             64'hDEAD_BEEF_CAFE_F00D, 64'h0, 1'b0, 1'b1));
        send_store(make_item(salf_pkg::CMD_SQC2, 32'hFFFF_FFF0, 16'h0010,
                             64'hA5A5_A5A5_5A5A_5A5A, 64'h5A5A_5A5A_A5A5_A5A5, 1'b0, 1'b1));
        send_store(make_item(salf_pkg::CMD_SQC2, 32'hFFFF_FFF0, 16'h0010,
                             64'hA5A5_A5A5_5A5A_5A5A, 64'h5A5A_5A5A_A5A5_A5A5, 1'b1, 1'b0));
    endtask

    task automatic test_unknown_commands();
        send_store(make_item(4'd11, 32'hFFFF_FFFF, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF,
                             64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
        send_store(make_item(4'd15, 32'h0000_0000, 16'h8000, 64'h0, 64'h0, 1'b0, 1'b0));
    endtask

    task automatic test_back_pressure();
        hold_request = 60;
        repeat (24)
            send_store(random_item());
    endtask

    task automatic test_drain_pause();
        repeat (10)
            send_store(random_item());
        store_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        @(negedge clk);
        repeat (10)
            send_store(random_item());
    endtask

    task automatic test_random_stores(input int count);
        for (int n = 0; n < count; n++)
        begin
            idling_on = !(n >= 300 && n < 450);
            send_store(random_item());
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        store_valid = 1'b0;
        store_item  = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_plain_stores();
        test_partial_stores();
        test_coprocessor_stores();
        test_unknown_commands();
        test_back_pressure();
        test_drain_pause();
        test_random_stores(860);
        store_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
